// ===== rtl/rbd_pkg.sv =====
// shared constants, register codes and lane control type for the rgba box downsampler
package rbd_pkg;

    localparam int unsigned DEF_MAX_OUT_WIDTH = 64;
    localparam int unsigned DEF_MAX_BIN       = 8;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned NUM_CHAN   = 4;
    localparam int unsigned PIX_W      = CHAN_W * NUM_CHAN;
    localparam int unsigned BIN_CFG_W  = 4;
    localparam int unsigned DIM_CFG_W  = 7;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [1:0] REG_BIN_FACTOR = 2'd0;
    localparam logic [1:0] REG_OUT_WIDTH  = 2'd1;
    localparam logic [1:0] REG_OUT_HEIGHT = 2'd2;

    localparam logic [BIN_CFG_W-1:0] BIN_RESET    = 4'd3;
    localparam logic [DIM_CFG_W-1:0] WIDTH_RESET  = 7'd16;
    localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 7'd16;

    typedef struct packed {
        logic acc;
        logic load;
        logic mul;
    } rbd_lane_ctl_t;

endpackage

// ===== rtl/rgba_box_downsampler_unit.sv =====
// top level of the rgba box downsampler: raster counters, column sum ram, lanes, output stage
//
// usage:
//   source pixels enter on the s_ stream, one transfer per pixel in raster order,
//   s_tdata = {alpha, blue, green, red}. the source image is bin*out_width wide and
//   bin*out_height high. one averaged pixel leaves on the m_ stream for every
//   bin x bin block, m_tlast marks the final output pixel of a frame.
//   bin_factor, out_width and out_height are written over the apb port (bytes 0, 4, 8)
//   while no pixel is in flight.
// timing:
//   a pixel that does not finish a block passes through the acc state only; a pixel
//   that finishes a block also passes through the mul and fix states, for the ram
//   read-modify-write followed by the two-step reciprocal divide in each channel lane.
//   m_tvalid rises once the fix state can load the output register (m_tvalid low or m_tready).
// reset:
//   aresetn clears the raster counters and the output valid and loads the register
//   defaults (bin 3, 16 x 16 output). the column sum ram is not cleared; the first
//   pixel of each block loads its column sum.
// stall:
//   a finished result waits in the output register while the next pixel is taken;
//   a second result then waits in the lanes until m_tready frees the register.
module rgba_box_downsampler_unit #(
    parameter int unsigned MAX_OUT_WIDTH = rbd_pkg::DEF_MAX_OUT_WIDTH,
    parameter int unsigned MAX_BIN       = rbd_pkg::DEF_MAX_BIN
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rbd_pkg::PIX_W-1:0]       s_tdata,   // red_in, green_in, blue_in, alpha_in
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rbd_pkg::PIX_W-1:0]       m_tdata,   // red_mean, green_mean, blue_mean, alpha_mean
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rbd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rbd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    import rbd_pkg::*;

    localparam int unsigned COL_W  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int unsigned SUB_W  = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1;
    localparam int unsigned BIN_W  = $clog2(MAX_BIN + 1);
    localparam int unsigned WEFF_W = $clog2(MAX_OUT_WIDTH + 1);
    localparam int unsigned SUM_W  = CHAN_W + 2 * $clog2(MAX_BIN);
    localparam int unsigned RAM_W  = NUM_CHAN * SUM_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIX  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [BIN_CFG_W-1:0]  bin_factor_reg;
    logic [DIM_CFG_W-1:0]  out_width_reg;
    logic [DIM_CFG_W-1:0]  out_height_reg;
    logic [SUB_W-1:0]      sub_col_reg, sub_col_next;
    logic [SUB_W-1:0]      sub_row_reg, sub_row_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [DIM_CFG_W-1:0]  out_row_reg, out_row_next;
    logic [PIX_W-1:0]      pix_reg;
    logic [COL_W-1:0]      col_reg;
    logic                  load_reg;
    logic                  emit_reg;
    logic                  last_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [PIX_W-1:0]      m_tdata_reg;
    logic                  m_tlast_reg;

    logic                  cfg_wr;
    logic                  s_xfer;
    logic [BIN_W-1:0]      bin_eff;
    logic [WEFF_W-1:0]     width_eff;
    logic [DIM_CFG_W-1:0]  height_eff;
    logic                  sub_col_last;
    logic                  sub_row_last;
    logic                  col_last;
    logic                  row_last;
    logic [COL_W-1:0]      col_addr;
    logic                  out_load;
    logic [RAM_W-1:0]      ram_rdata;
    logic [RAM_W-1:0]      ram_wdata;
    logic [CHAN_W-1:0]     mean [NUM_CHAN];
    logic [PIX_W-1:0]      mean_packed;
    rbd_lane_ctl_t         lane_ctl;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_factor_reg <= BIN_RESET;
            out_width_reg  <= WIDTH_RESET;
            out_height_reg <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_BIN_FACTOR: bin_factor_reg <= pwdata[BIN_CFG_W-1:0];
                REG_OUT_WIDTH:  out_width_reg  <= pwdata[DIM_CFG_W-1:0];
                REG_OUT_HEIGHT: out_height_reg <= pwdata[DIM_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BIN_FACTOR: prdata = CFG_DATA_W'(bin_factor_reg);
            REG_OUT_WIDTH:  prdata = CFG_DATA_W'(out_width_reg);
            REG_OUT_HEIGHT: prdata = CFG_DATA_W'(out_height_reg);
            default:        prdata = '0;
        endcase
    end

    // effective settings
    always_comb begin
        if (bin_factor_reg == '0) begin
            bin_eff = BIN_W'(1);
        end else if (32'(bin_factor_reg) > MAX_BIN) begin
            bin_eff = BIN_W'(MAX_BIN);
        end else begin
            bin_eff = BIN_W'(bin_factor_reg);
        end
        if (out_width_reg == '0) begin
            width_eff = WEFF_W'(1);
        end else if (32'(out_width_reg) > MAX_OUT_WIDTH) begin
            width_eff = WEFF_W'(MAX_OUT_WIDTH);
        end else begin
            width_eff = WEFF_W'(out_width_reg);
        end
        height_eff = (out_height_reg == '0) ? DIM_CFG_W'(1) : out_height_reg;
    end

    // raster position
    assign sub_col_last = (32'(sub_col_reg) + 32'd1) >= 32'(bin_eff);
    assign sub_row_last = (32'(sub_row_reg) + 32'd1) >= 32'(bin_eff);
    assign col_last     = (32'(out_col_reg) + 32'd1) >= 32'(width_eff);
    assign row_last     = (32'(out_row_reg) + 32'd1) >= 32'(height_eff);
    assign col_addr     = (32'(out_col_reg) >= 32'(width_eff)) ? COL_W'(width_eff - 1'b1)
                                                               : out_col_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid & s_tready;

    always_comb begin
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (s_xfer) begin
            if (sub_col_last) begin
                sub_col_next = '0;
                if (col_last) begin
                    out_col_next = '0;
                    if (sub_row_last) begin
                        sub_row_next = '0;
                        out_row_next = row_last ? '0 : out_row_reg + 1'b1;
                    end else begin
                        sub_row_next = sub_row_reg + 1'b1;
                    end
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end else begin
                sub_col_next = sub_col_reg + 1'b1;
            end
        end
    end

    // sequencer
    assign out_load = (state_reg == ST_FIX) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_xfer) state_next = ST_ACC;
            ST_ACC:  state_next = emit_reg ? ST_MUL : ST_IDLE;
            ST_MUL:  state_next = ST_FIX;
            ST_FIX:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sub_col_reg  <= '0;
            sub_row_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sub_col_reg  <= sub_col_next;
            sub_row_reg  <= sub_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pix_reg  <= s_tdata;
            col_reg  <= col_addr;
            load_reg <= (sub_col_reg == '0) && (sub_row_reg == '0);
            emit_reg <= sub_col_last && sub_row_last;
            last_reg <= col_last && row_last;
        end
    end

    // column sums
    rbd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_OUT_WIDTH),
        .AW    (COL_W)
    ) u_sums (
        .clk   (aclk),
        .we    (state_reg == ST_ACC),
        .waddr (col_reg),
        .wdata (ram_wdata),
        .re    (s_xfer),
        .raddr (col_addr),
        .rdata (ram_rdata)
    );

    // channel lanes
    assign lane_ctl.acc  = (state_reg == ST_ACC);
    assign lane_ctl.load = load_reg;
    assign lane_ctl.mul  = (state_reg == ST_MUL);

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
        rbd_lane #(
            .MAX_BIN (MAX_BIN),
            .BIN_W   (BIN_W),
            .SUM_W   (SUM_W)
        ) u_lane (
            .clk     (aclk),
            .ctl     (lane_ctl),
            .pix     (pix_reg[c*CHAN_W +: CHAN_W]),
            .ram_sum (ram_rdata[c*SUM_W +: SUM_W]),
            .bin     (bin_eff),
            .sum_new (ram_wdata[c*SUM_W +: SUM_W]),
            .mean    (mean[c])
        );
    end

    // merge lanes into the output register
    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            mean_packed[c*CHAN_W +: CHAN_W] = mean[c];
        end
    end

    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= mean_packed;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== rtl/rbd_ram.sv =====
// generic single-port-write, registered-read ram
module rbd_ram #(
    parameter int unsigned WIDTH = 56,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rbd_lane.sv =====
// one channel lane: column sum accumulate and truncated divide by bin squared
module rbd_lane #(
    parameter int unsigned MAX_BIN = 8,
    parameter int unsigned BIN_W   = 4,
    parameter int unsigned SUM_W   = 14
) (
    input  logic                        clk,
    input  rbd_pkg::rbd_lane_ctl_t      ctl,
    input  logic [rbd_pkg::CHAN_W-1:0]  pix,
    input  logic [SUM_W-1:0]            ram_sum,
    input  logic [BIN_W-1:0]            bin,
    output logic [SUM_W-1:0]            sum_new,
    output logic [rbd_pkg::CHAN_W-1:0]  mean
);

    import rbd_pkg::*;

    localparam int unsigned K      = SUM_W;
    localparam int unsigned RCP_W  = K + 1;
    localparam int unsigned DIV_W  = 2 * BIN_W;
    localparam int unsigned PROD_W = SUM_W + RCP_W;
    localparam int unsigned QD_W   = SUM_W + DIV_W;

    logic [RCP_W-1:0]  rcp_tab [MAX_BIN+1];
    logic [DIV_W-1:0]  divisor;
    logic [SUM_W-1:0]  sum_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  q_est;
    logic [QD_W-1:0]   qd;
    logic [QD_W-1:0]   rem;
    logic [SUM_W-1:0]  quot;

    // reciprocal table, floor(2^K / b^2)
    for (genvar b = 0; b <= MAX_BIN; b++) begin : g_rcp
        localparam longint unsigned DIVISOR = (b == 0) ? 1 : b * b;
        localparam longint unsigned RCP     = (64'd1 << K) / DIVISOR;
        assign rcp_tab[b] = RCP[RCP_W-1:0];
    end

    assign divisor = {{BIN_W{1'b0}}, bin} * {{BIN_W{1'b0}}, bin};
    assign sum_new = ctl.load ? SUM_W'(pix) : ram_sum + SUM_W'(pix);

    always_ff @(posedge clk) begin
        if (ctl.acc) begin
            sum_reg <= sum_new;
        end
        if (ctl.mul) begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(rcp_tab[bin]);
        end
    end

    // estimate is exact or one low
    always_comb begin
        q_est = prod_reg[K+SUM_W-1:K];
        qd    = QD_W'(q_est) * QD_W'(divisor);
        rem   = QD_W'(sum_reg) - qd;
        quot  = (rem >= QD_W'(divisor)) ? q_est + SUM_W'(1) : q_est;
        mean  = (quot > SUM_W'(8'hFF)) ? 8'hFF : quot[CHAN_W-1:0];
    end

endmodule

// ===== rtl/rbd_checker.sv =====
// port-level checks for the rgba box downsampler and their bind
module rbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // one pixel at a time, the block is busy right after a transfer
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in back to back cycles");

    // a new result comes from the input transfer that led through the acc, mul and fix states
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
        else $error("result without matching input transfer");

    // the block is idle and ready for input in the cycle a fresh result appears
    a_no_in_on_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("block not idle when result appeared");

endmodule

bind rgba_box_downsampler_unit rbd_checker u_rbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== dv/rgba_box_downsampler_unit_tb.sv =====
// self-checking testbench for rgba_box_downsampler_unit: raster pixel streams against a box average predictor
`timescale 1ns / 1ps

module rgba_box_downsampler_unit_tb;
    import rbd_pkg::*;

    localparam int unsigned RUN_LIMIT      = 400000;
    localparam int unsigned ITEMS_PER_MODE = 670;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned REPORT_MAX     = 10;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgba_t;

    typedef struct {
        rgba_t mean;
        logic  frame_end;
    } block_mean_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [PIX_W-1:0]      s_tdata  = '0;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic [BIN_CFG_W-1:0] bin_reg    = BIN_RESET;
    logic [DIM_CFG_W-1:0] width_reg  = WIDTH_RESET;
    logic [DIM_CFG_W-1:0] height_reg = HEIGHT_RESET;

    int unsigned col_sum [DEF_MAX_OUT_WIDTH][NUM_CHAN];
    int unsigned sub_col;
    int unsigned out_col;
    int unsigned sub_row;
    int unsigned out_row;

    rgba_t       pix_q[$];
    block_mean_t means_q[$];

    int unsigned tx_idle_pct  = 25;
    int unsigned rx_stall_pct = 45;
    bit          pix_taken    = 1'b0;
    int unsigned errors       = 0;
    int unsigned cycles       = 0;

    always #5 aclk = ~aclk;

    rgba_box_downsampler_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    function automatic int unsigned eff_bin();
        if (bin_reg == 0) return 1;
        if (bin_reg > DEF_MAX_BIN) return DEF_MAX_BIN;
        return 32'(bin_reg);
    endfunction

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > DEF_MAX_OUT_WIDTH) return DEF_MAX_OUT_WIDTH;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : 32'(height_reg);
    endfunction

    function automatic rgba_t rand_pixel();
        logic [PIX_W-1:0] p;
        p = $urandom();
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            case ($urandom_range(5))
                0: p[ch*CHAN_W +: CHAN_W] = '0;
                1: p[ch*CHAN_W +: CHAN_W] = '1;
                default: ;
            endcase
        end
        return rgba_t'(p);
    endfunction

    task automatic box_average_step(input rgba_t pix);
        int unsigned      b;
        int unsigned      w;
        int unsigned      h;
        int unsigned      col;
        int unsigned      m;
        logic [PIX_W-1:0] packed_mean;
        block_mean_t      res;
        b = eff_bin();
        w = eff_width();
        h = eff_height();
        col = (out_col >= w) ? w - 1 : out_col;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            if (sub_row == 0 && sub_col == 0)
                col_sum[col][ch] = 32'(pix[ch*CHAN_W +: CHAN_W]);
            else
                col_sum[col][ch] += 32'(pix[ch*CHAN_W +: CHAN_W]);
        end
        if (sub_col + 1 >= b && sub_row + 1 >= b) begin
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
                m = col_sum[col][ch] / (b * b);
                if (m > 255) m = 255;
                packed_mean[ch*CHAN_W +: CHAN_W] = m[CHAN_W-1:0];
            end
            res.mean = rgba_t'(packed_mean);
            res.frame_end = (out_col + 1 >= w && out_row + 1 >= h);
            means_q.push_back(res);
        end
        if (sub_col + 1 >= b) begin
            sub_col = 0;
            if (out_col + 1 >= w) begin
                out_col = 0;
                if (sub_row + 1 >= b) begin
                    sub_row = 0;
                    out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
                end else begin
                    sub_row++;
                end
            end else begin
                out_col++;
            end
        end else begin
            sub_col++;
        end
    endtask

    task automatic note_mismatch(input string what);
        errors++;
        if (errors <= REPORT_MAX) $display("%s", what);
    endtask

    task automatic csr_write(input logic [1:0] idx, input logic [DIM_CFG_W-1:0] val);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        if (idx == REG_BIN_FACTOR)
            pwdata <= {junk[CFG_DATA_W-1:BIN_CFG_W], val[BIN_CFG_W-1:0]};
        else
            pwdata <= {junk[CFG_DATA_W-1:DIM_CFG_W], val};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_BIN_FACTOR: bin_reg    = val[BIN_CFG_W-1:0];
            REG_OUT_WIDTH:  width_reg  = val;
            REG_OUT_HEIGHT: height_reg = val;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle();
        while (pix_q.size() != 0 || s_tvalid || means_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // source side
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || pix_taken)) begin
            if (pix_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pix_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        pix_taken = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            box_average_step(rgba_t'(s_tdata));
            pix_taken = 1'b1;
        end
    end

    // result side
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= rx_stall_pct);

    always @(posedge aclk) begin : result_check
        block_mean_t want;
        rgba_t       got;
        got = rgba_t'(m_tdata);
        if (aresetn && m_tvalid && m_tready) begin
            if (means_q.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer: r=%0d g=%0d b=%0d a=%0d last=%0b",
                    got.red, got.green, got.blue, got.alpha, m_tlast));
            end else begin
                want = means_q.pop_front();
                if (got.red !== want.mean.red || got.green !== want.mean.green ||
                    got.blue !== want.mean.blue || got.alpha !== want.mean.alpha ||
                    m_tlast !== want.frame_end)
                    note_mismatch($sformatf({"mean mismatch: expected r=%0d g=%0d b=%0d a=%0d",
                        " last=%0b, got r=%0d g=%0d b=%0d a=%0d last=%0b"},
                        want.mean.red, want.mean.green, want.mean.blue, want.mean.alpha,
                        want.frame_end, got.red, got.green, got.blue, got.alpha, m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= RUN_LIMIT) begin
            $display("rgba_box_downsampler_unit verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [BIN_CFG_W-1:0] ext_bin [6];
        logic [DIM_CFG_W-1:0] ext_w [6];
        logic [DIM_CFG_W-1:0] ext_h [6];
        logic [BIN_CFG_W-1:0] b;
        logic [DIM_CFG_W-1:0] w;
        logic [DIM_CFG_W-1:0] h;
        int unsigned          fed;
        int unsigned          frame_no;
        int unsigned          total;
        ext_bin = '{4'd15, 4'd1, 4'd8, 4'd0, 4'd1, 4'd2};
        ext_w   = '{7'd1, 7'd127, 7'd2, 7'd64, 7'd1, 7'd64};
        ext_h   = '{7'd1, 7'd1, 7'd2, 7'd2, 7'd127, 7'd1};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero settings fall back to a 1x1 frame of 1x1 blocks
        csr_write(REG_BIN_FACTOR, 7'd0);
        csr_write(REG_OUT_WIDTH, 7'd0);
        csr_write(REG_OUT_HEIGHT, 7'd0);
        pix_q.push_back(rgba_t'(32'h0000_0000));
        pix_q.push_back(rgba_t'(32'hFFFF_FFFF));
        pix_q.push_back(rgba_t'(32'h0180_7FFE));
        settle();

        // full-scale block and truncation
        csr_write(REG_BIN_FACTOR, 7'd2);
        csr_write(REG_OUT_WIDTH, 7'd2);
        csr_write(REG_OUT_HEIGHT, 7'd1);
        pix_q.push_back(rgba_t'(32'hFFFF_FFFF));
        pix_q.push_back(rgba_t'(32'hFFFF_FFFF));
        pix_q.push_back(rgba_t'(32'h0000_00FF));
        pix_q.push_back(rgba_t'(32'h0000_0000));
        pix_q.push_back(rgba_t'(32'hFFFF_FFFF));
        pix_q.push_back(rgba_t'(32'hFFFF_FFFF));
        pix_q.push_back(rgba_t'(32'h0000_0000));
        pix_q.push_back(rgba_t'(32'h0000_0000));
        settle();

        // bin shrinks mid-band: overfull block sum saturates the mean
        csr_write(REG_BIN_FACTOR, 7'd3);
        csr_write(REG_OUT_WIDTH, 7'd1);
        csr_write(REG_OUT_HEIGHT, 7'd1);
        repeat (6) pix_q.push_back(rgba_t'(32'hFFFF_FFFF));
        settle();
        csr_write(REG_BIN_FACTOR, 7'd2);
        repeat (2) pix_q.push_back(rgba_t'(32'hFFFF_FFFF));
        settle();

        // width shrinks mid-row: column counter beyond the new width
        csr_write(REG_BIN_FACTOR, 7'd1);
        csr_write(REG_OUT_WIDTH, 7'd4);
        csr_write(REG_OUT_HEIGHT, 7'd2);
        repeat (3) pix_q.push_back(rand_pixel());
        settle();
        csr_write(REG_OUT_WIDTH, 7'd2);
        repeat (3) pix_q.push_back(rand_pixel());
        settle();

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct  = (mode == 0) ? 25 : (mode == 1) ? 45 : 0;
            rx_stall_pct = (mode == 0) ? 45 : (mode == 1) ? 25 : 0;
            fed = 0;
            frame_no = 0;
            while (fed < ITEMS_PER_MODE) begin
                if (frame_no < 2) begin
                    b = ext_bin[mode*2 + frame_no];
                    w = ext_w[mode*2 + frame_no];
                    h = ext_h[mode*2 + frame_no];
                end else begin
                    case ($urandom_range(3))
                        0, 1: begin
                            b = BIN_CFG_W'($urandom_range(3));
                            w = DIM_CFG_W'($urandom_range(12));
                            h = DIM_CFG_W'($urandom_range(4));
                        end
                        2: begin
                            b = BIN_CFG_W'($urandom_range(15, 5));
                            w = DIM_CFG_W'($urandom_range(2));
                            h = DIM_CFG_W'($urandom_range(1));
                        end
                        default: begin
                            b = BIN_CFG_W'($urandom_range(1));
                            w = DIM_CFG_W'($urandom_range(127));
                            h = DIM_CFG_W'($urandom_range(3));
                        end
                    endcase
                end
                csr_write(REG_BIN_FACTOR, DIM_CFG_W'(b));
                csr_write(REG_OUT_WIDTH, w);
                csr_write(REG_OUT_HEIGHT, h);
                total = eff_bin() * eff_width() * eff_bin() * eff_height();
                if (frame_no >= 2) total = total * $urandom_range(2, 1);
                for (int k = 0; k < total; k++) begin
                    if (frame_no == 3 && k == total / 2) settle();
                    pix_q.push_back(rand_pixel());
                end
                fed += total;
                frame_no++;
                settle();
            end
        end

        if (errors == 0)
            $display("rgba_box_downsampler_unit verification clean");
        else
            $display("rgba_box_downsampler_unit verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rbd_pkg.sv
rtl/rbd_ram.sv
rtl/rbd_lane.sv
rtl/rgba_box_downsampler_unit.sv
rtl/rbd_checker.sv
dv/rgba_box_downsampler_unit_tb.sv
